### design/point_set_min_distance_contact_defines.svh
// ---------------------------------------------------------------------------
// point_set_min_distance_contact_defines
// Assertion macros shared by the point set distance block.
// ---------------------------------------------------------------------------
`ifndef POINT_SET_MIN_DISTANCE_CONTACT_DEFINES_SVH
`define POINT_SET_MIN_DISTANCE_CONTACT_DEFINES_SVH
`ifndef SYNTHESIS
// pre holds in a cycle -> post holds in the same cycle
`define PSMD_ASSERT_IMPL(name, pre, post) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("psmd assertion failed");
// pre holds in a cycle -> post holds in the next cycle
`define PSMD_ASSERT_NEXT(name, pre, post) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("psmd assertion failed");
`else
`define PSMD_ASSERT_IMPL(name, pre, post)
`define PSMD_ASSERT_NEXT(name, pre, post)
`endif
`endif

### design/psmd_pkg.sv
// ---------------------------------------------------------------------------
// psmd_pkg
// Types and fixed constants of the point set distance block.
// ---------------------------------------------------------------------------
package psmd_pkg;

  localparam int NUM_AXES = 3;
  localparam int CELL_LAT = 3;       // register stages in one distance cell

  localparam int CFG_W    = 24;      // widest configuration register
  localparam int DIST_W   = 26;
  localparam int CNT_A_W  = 11;
  localparam int CNT_B_W  = 16;

  localparam logic [CFG_W-1:0]   CD_RESET  = 24'd983;  // three times 0.005 in Q8.16
  localparam logic [CNT_A_W-1:0] MCP_RESET = 11'd5;

  localparam logic [DIST_W-1:0]  DIST_MAX  = '1;
  localparam logic [CNT_A_W-1:0] CNT_A_MAX = '1;
  localparam logic [CNT_B_W-1:0] CNT_B_MAX = '1;

  // configuration register indexes
  localparam logic CFG_CONTACT_DISTANCE = 1'b0;
  localparam logic CFG_MIN_CONTACT      = 1'b1;

  // item function codes
  localparam logic FUNC_LOAD    = 1'b0;
  localparam logic FUNC_COMPARE = 1'b1;

  // control that travels with each stored point down the cell chain
  typedef struct packed {
    logic valid;
    logic mark;   // contact mark of the stored point when it was read
  } psmd_tag_t;

endpackage

### design/point_set_min_distance_contact.sv
// ---------------------------------------------------------------------------
// point_set_min_distance_contact
// Closest distance and contact count between two 3-D point sets.
// ---------------------------------------------------------------------------
// A load item (func 0) is written into the point store. A compare item
// (func 1) walks the N stored points through the store's read port, one
// point per cycle, into a chain of three distance cells (one per axis,
// three stages each); no next item is taken until the last point has left
// the chain. A compare item that carries last_point further runs the
// square root unit at one bit a cycle and then posts the result, which
// waits in an output register while loading carries on.
// After the result the store is empty again; no clearing pass is needed.
// ---------------------------------------------------------------------------
`include "point_set_min_distance_contact_defines.svh"

module point_set_min_distance_contact
  import psmd_pkg::*;
#(
  parameter int MAX_POINTS = 1024,
  parameter int COORD_BITS = 24
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic                         cfg_index,
  input  logic [CFG_W-1:0]             cfg_wdata,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         in_func,
  input  logic signed [COORD_BITS-1:0] in_coord_x,
  input  logic signed [COORD_BITS-1:0] in_coord_y,
  input  logic signed [COORD_BITS-1:0] in_coord_z,
  input  logic                         in_last_point,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [DIST_W-1:0]            out_min_distance,
  output logic                         out_stable,
  output logic [CNT_A_W-1:0]           out_contact_count_a,
  output logic [CNT_B_W-1:0]           out_contact_count_b,
  output logic                         out_store_overflow
);

  localparam int C     = COORD_BITS;
  localparam int CW    = NUM_AXES * COORD_BITS;
  localparam int SQ_W  = 2 * COORD_BITS + 2;
  localparam int R_W   = COORD_BITS + 1;
  localparam int IDX_W = $clog2(MAX_POINTS);
  localparam int CNT_W = $clog2(MAX_POINTS + 1);
  localparam int THR_W = 2 * CFG_W;
  localparam int CMP_W = (SQ_W > THR_W) ? SQ_W : THR_W;
  localparam int RX_W  = (R_W > DIST_W) ? R_W : DIST_W;
  localparam int LAT   = 1 + NUM_AXES * CELL_LAT;
  localparam int DR_W  = $clog2(LAT + 1);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_SCAN  = 5'b00010,
    S_DRAIN = 5'b00100,
    S_SQRT  = 5'b01000,
    S_RES   = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  // configuration
  logic [CFG_W-1:0]   cd_r;
  logic [CNT_A_W-1:0] mcp_r;
  logic [THR_W-1:0]   thr_r;

  // running pass state
  logic [CNT_W-1:0]   count_r;
  logic [CNT_W-1:0]   scan_r;
  logic [DR_W-1:0]    drain_r;
  logic [SQ_W-1:0]    min_r;
  logic [CNT_A_W-1:0] cnta_r;
  logic [CNT_B_W-1:0] cntb_r;
  logic               ovf_r;
  logic               hit_r;
  logic               last_r;

  // point store and contact marks
  logic [CW-1:0] pt_mem [MAX_POINTS];
  logic          mark_mem [MAX_POINTS];
  logic [CW-1:0]    rd_coords_r;
  logic [IDX_W-1:0] rd_idx_r;
  psmd_tag_t        rd_tag_r;

  // cell chain
  psmd_tag_t        ch_tag    [NUM_AXES+1];
  logic [IDX_W-1:0] ch_idx    [NUM_AXES+1];
  logic [CW-1:0]    ch_coords [NUM_AXES+1];
  logic [SQ_W-1:0]  ch_sum    [NUM_AXES+1];
  logic [CW-1:0]    b_vec;

  // square root
  logic             sq_start;
  logic             sq_done;
  logic [R_W-1:0]   sq_root;

  // output register
  logic               out_valid_r;
  logic [DIST_W-1:0]  out_dist_r;
  logic               out_stable_r;
  logic [CNT_A_W-1:0] out_cnta_r;
  logic [CNT_B_W-1:0] out_cntb_r;
  logic               out_ovf_r;

  logic             in_acc;
  logic             load_acc;
  logic             cmp_acc;
  logic             store_full;
  logic             scan_last;
  logic             drain_end;
  logic             res_load;
  logic             end_v;
  logic             end_hit;
  logic             mark_we;
  logic [IDX_W-1:0] mark_wa;
  logic             mark_wd;
  logic [RX_W-1:0]  root_x;
  logic [DIST_W-1:0] dist_val;

  assign in_ready   = (state_r == S_IDLE);
  assign in_acc     = in_valid && in_ready;
  assign load_acc   = in_acc && (in_func == FUNC_LOAD);
  assign cmp_acc    = in_acc && (in_func == FUNC_COMPARE);
  assign store_full = (count_r == CNT_W'(MAX_POINTS));
  assign scan_last  = ((scan_r + CNT_W'(1)) == count_r);
  assign drain_end  = (state_r == S_DRAIN) && (drain_r == '0);
  assign res_load   = (state_r == S_RES) && (!out_valid_r || out_ready);
  assign sq_start   = drain_end && last_r;

  assign end_v   = ch_tag[NUM_AXES].valid;
  assign end_hit = end_v && (CMP_W'(ch_sum[NUM_AXES]) < CMP_W'(thr_r));

  // ---------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cd_r  <= CD_RESET;
      mcp_r <= MCP_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_CONTACT_DISTANCE: cd_r  <= cfg_wdata;
        CFG_MIN_CONTACT:      mcp_r <= cfg_wdata[CNT_A_W-1:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    thr_r <= cd_r * cd_r;
  end

  // ---------------------------------------------------------------------
  // sequencer
  // ---------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (cmp_acc) begin
          state_nxt = (count_r == '0) ? S_DRAIN : S_SCAN;
        end
      end
      S_SCAN: begin
        if (scan_last) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (drain_end) begin
          state_nxt = last_r ? S_SQRT : S_IDLE;
        end
      end
      S_SQRT: begin
        if (sq_done) begin
          state_nxt = S_RES;
        end
      end
      S_RES: begin
        if (res_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      scan_r  <= '0;
      drain_r <= '0;
      min_r   <= '1;
      cnta_r  <= '0;
      cntb_r  <= '0;
      ovf_r   <= 1'b0;
      hit_r   <= 1'b0;
      last_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (load_acc) begin
        if (store_full) begin
          ovf_r <= 1'b1;
        end else begin
          count_r <= count_r + CNT_W'(1);
        end
      end
      if (cmp_acc) begin
        scan_r  <= '0;
        drain_r <= DR_W'(LAT);
        last_r  <= in_last_point;
      end
      if (state_r == S_SCAN) begin
        scan_r <= scan_r + CNT_W'(1);
      end
      if (state_r == S_DRAIN && drain_r != '0) begin
        drain_r <= drain_r - DR_W'(1);
      end
      if (state_r == S_SCAN && scan_last) begin
        drain_r <= DR_W'(LAT);
      end
      // fold in each finished pair at the chain end
      if (end_v) begin
        if (ch_sum[NUM_AXES] < min_r) begin
          min_r <= ch_sum[NUM_AXES];
        end
        if (end_hit) begin
          hit_r <= 1'b1;
          if (!ch_tag[NUM_AXES].mark && cnta_r != CNT_A_MAX) begin
            cnta_r <= cnta_r + CNT_A_W'(1);
          end
        end
      end
      if (drain_end) begin
        hit_r <= 1'b0;
        if (hit_r && cntb_r != CNT_B_MAX) begin
          cntb_r <= cntb_r + CNT_B_W'(1);
        end
      end
      // result posted: empty both sets, keep the configuration
      if (res_load) begin
        count_r <= '0;
        min_r   <= '1;
        cnta_r  <= '0;
        cntb_r  <= '0;
        ovf_r   <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------
  // point store and contact mark store
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (load_acc && !store_full) begin
      pt_mem[count_r[IDX_W-1:0]] <= {in_coord_z, in_coord_y, in_coord_x};
    end
    rd_coords_r <= pt_mem[scan_r[IDX_W-1:0]];
  end

  always_comb begin
    priority if (load_acc) begin
      mark_we = !store_full;
      mark_wa = count_r[IDX_W-1:0];
      mark_wd = 1'b0;
    end else begin
      mark_we = end_hit && !ch_tag[NUM_AXES].mark;
      mark_wa = ch_idx[NUM_AXES];
      mark_wd = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mark_we) begin
      mark_mem[mark_wa] <= mark_wd;
    end
    rd_tag_r.mark <= mark_mem[scan_r[IDX_W-1:0]];
    rd_idx_r      <= scan_r[IDX_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_tag_r.valid <= 1'b0;
    end else begin
      rd_tag_r.valid <= (state_r == S_SCAN);
    end
  end

  // ---------------------------------------------------------------------
  // distance chain, one cell per axis
  // ---------------------------------------------------------------------
  assign b_vec        = {in_coord_z, in_coord_y, in_coord_x};
  assign ch_tag[0]    = rd_tag_r;
  assign ch_idx[0]    = rd_idx_r;
  assign ch_coords[0] = rd_coords_r;
  assign ch_sum[0]    = '0;

  for (genvar g = 0; g < NUM_AXES; g++) begin : g_cell
    psmd_cell #(
      .COORD_BITS (COORD_BITS),
      .IDX_W      (IDX_W)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .b_load     (cmp_acc),
      .b_in       (b_vec[g*C +: C]),
      .tag_in     (ch_tag[g]),
      .idx_in     (ch_idx[g]),
      .coords_in  (ch_coords[g]),
      .sum_in     (ch_sum[g]),
      .tag_out    (ch_tag[g+1]),
      .idx_out    (ch_idx[g+1]),
      .coords_out (ch_coords[g+1]),
      .sum_out    (ch_sum[g+1])
    );
  end

  // ---------------------------------------------------------------------
  // square root and result register
  // ---------------------------------------------------------------------
  psmd_sqrt #(
    .COORD_BITS (COORD_BITS)
  ) u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sq_start),
    .radicand (min_r),
    .done     (sq_done),
    .root     (sq_root)
  );

  assign root_x = RX_W'(sq_root);

  always_comb begin
    priority if (min_r == '1) begin
      dist_val = DIST_MAX;
    end else if (root_x > RX_W'(DIST_MAX)) begin
      dist_val = DIST_MAX;
    end else begin
      dist_val = root_x[DIST_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      out_dist_r   <= dist_val;
      out_stable_r <= (cnta_r > mcp_r) && (cntb_r > CNT_B_W'(mcp_r));
      out_cnta_r   <= cnta_r;
      out_cntb_r   <= cntb_r;
      out_ovf_r    <= ovf_r;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_min_distance    = out_dist_r;
  assign out_stable          = out_stable_r;
  assign out_contact_count_a = out_cnta_r;
  assign out_contact_count_b = out_cntb_r;
  assign out_store_overflow  = out_ovf_r;

  // ---------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------
  `PSMD_ASSERT_IMPL(a_scan_in_range, state_r == S_SCAN, scan_r < count_r)
  `PSMD_ASSERT_IMPL(a_count_bound, 1'b1, count_r <= CNT_W'(MAX_POINTS))
  `PSMD_ASSERT_IMPL(a_chain_in_pass, end_v, state_r == S_SCAN || state_r == S_DRAIN)
  `PSMD_ASSERT_IMPL(a_sqrt_done_state, sq_done, state_r == S_SQRT)
  `PSMD_ASSERT_NEXT(a_result_clears, res_load, out_valid_r && count_r == '0 && cntb_r == '0)

endmodule

### design/psmd_cell.sv
// ---------------------------------------------------------------------------
// psmd_cell
// One axis of the distance chain: holds one B coordinate, adds the squared
// difference against the low coordinate of the passing A point.
// ---------------------------------------------------------------------------
module psmd_cell
  import psmd_pkg::*;
#(
  parameter int COORD_BITS = 24,
  parameter int IDX_W      = 10
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            b_load,
  input  logic [COORD_BITS-1:0]           b_in,
  input  psmd_tag_t                       tag_in,
  input  logic [IDX_W-1:0]                idx_in,
  input  logic [NUM_AXES*COORD_BITS-1:0]  coords_in,
  input  logic [2*COORD_BITS+1:0]         sum_in,
  output psmd_tag_t                       tag_out,
  output logic [IDX_W-1:0]                idx_out,
  output logic [NUM_AXES*COORD_BITS-1:0]  coords_out,
  output logic [2*COORD_BITS+1:0]         sum_out
);

  localparam int C    = COORD_BITS;
  localparam int CW   = NUM_AXES * COORD_BITS;
  localparam int SQ_W = 2 * COORD_BITS + 2;

  logic [C-1:0]    b_r;
  logic [C:0]      diff;
  logic [C:0]      mag;
  logic [SQ_W-1:0] sq;

  logic [C:0]      mag1_r;
  logic [SQ_W-1:0] sum1_r, sum2_r, sum3_r, sq2_r;
  logic [CW-1:0]   coords1_r, coords2_r, coords3_r;
  logic [IDX_W-1:0] idx1_r, idx2_r, idx3_r;
  psmd_tag_t       tag1_r, tag2_r, tag3_r;

  always_ff @(posedge clk) begin
    if (b_load) begin
      b_r <= b_in;
    end
  end

  assign diff = {coords_in[C-1], coords_in[C-1:0]} - {b_r[C-1], b_r};
  assign mag  = diff[C] ? (~diff + (C+1)'(1)) : diff;
  assign sq   = mag1_r * mag1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag1_r <= '0;
      tag2_r <= '0;
      tag3_r <= '0;
    end else begin
      tag1_r <= tag_in;
      tag2_r <= tag1_r;
      tag3_r <= tag2_r;
    end
  end

  always_ff @(posedge clk) begin
    mag1_r    <= mag;
    sum1_r    <= sum_in;
    coords1_r <= coords_in;
    idx1_r    <= idx_in;
    sq2_r     <= sq;
    sum2_r    <= sum1_r;
    coords2_r <= coords1_r;
    idx2_r    <= idx1_r;
    sum3_r    <= sum2_r + sq2_r;
    // rotate so the next cell finds its own axis in the low bits
    coords3_r <= {coords2_r[C-1:0], coords2_r[CW-1:C]};
    idx3_r    <= idx2_r;
  end

  assign tag_out    = tag3_r;
  assign idx_out    = idx3_r;
  assign coords_out = coords3_r;
  assign sum_out    = sum3_r;

endmodule

### design/psmd_sqrt.sv
// ---------------------------------------------------------------------------
// psmd_sqrt
// Restoring integer square root, one result bit per cycle.
// ---------------------------------------------------------------------------
module psmd_sqrt
  import psmd_pkg::*;
#(
  parameter int COORD_BITS = 24
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic [2*COORD_BITS+1:0] radicand,
  output logic                    done,
  output logic [COORD_BITS:0]     root
);

  localparam int SQ_W = 2 * COORD_BITS + 2;
  localparam int R_W  = COORD_BITS + 1;
  localparam int IT_W = $clog2(R_W + 1);

  logic [SQ_W-1:0] rad_r;
  logic [R_W+1:0]  rem_r;
  logic [R_W-1:0]  root_r;
  logic [IT_W-1:0] iter_r;
  logic            busy_r;
  logic            done_r;

  logic [R_W+1:0]  rem_sh;
  logic [R_W+1:0]  trial;
  logic            take;

  assign rem_sh = {rem_r[R_W-1:0], rad_r[SQ_W-1:SQ_W-2]};
  assign trial  = {root_r, 2'b01};
  assign take   = (rem_sh >= trial);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      iter_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        iter_r <= IT_W'(R_W);
      end else if (busy_r) begin
        iter_r <= iter_r - IT_W'(1);
        if (iter_r == IT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad_r  <= radicand;
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      rad_r  <= {rad_r[SQ_W-3:0], 2'b00};
      rem_r  <= take ? (rem_sh - trial) : rem_sh;
      root_r <= {root_r[R_W-2:0], take};
    end
  end

  assign done = done_r;
  assign root = root_r;

endmodule

### tb/sv/point_set_min_distance_contact_test.sv
// ---------------------------------------------------------------------------
// point_set_min_distance_contact_test
// Self-checking bench for the point set distance and contact block.
// ---------------------------------------------------------------------------
// Set A points are loaded, then set B points are compared against them. A
// behavioural model of the block runs next to it and keeps its own point
// store, contact marks, minimum squared distance and contact radius. Every
// accepted item updates that model, and each last B point queues the
// expected distance, contact counts and flags. A short list of hand-picked
// items comes first: the empty set, the radius boundary, coordinate
// extremes and a last flag on a load. Random passes follow under a range of
// radius and count settings, one of them with a full store. Both handshakes
// stall at random.
// ---------------------------------------------------------------------------
module point_set_min_distance_contact_test;
  import psmd_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_POINTS   = 1024;
  localparam int COORD_W      = 24;
  localparam int RANDOM_ITEMS = 580;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int CFG_QUIET    = 64;
  localparam int END_QUIET    = MAX_POINTS + 64;
  localparam int CALM_START   = 2000;
  localparam int CALM_END     = 8000;
  localparam int N_DIRECTED   = 16;

  localparam logic signed [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
  localparam logic signed [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

  typedef logic [63:0] sq_t;
  localparam sq_t NO_PAIR = '1;

  typedef struct packed {
    logic                      func;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
    logic                      last;
  } point_item_t;

  typedef struct packed {
    logic [DIST_W-1:0]  min_distance;
    logic               stable;
    logic [CNT_A_W-1:0] count_a;
    logic [CNT_B_W-1:0] count_b;
    logic               overflow;
  } contact_result_t;

  typedef struct {
    point_item_t     item;
    bit              checked;
    contact_result_t want;
  } directed_row_t;

  localparam contact_result_t EMPTY_RESULT = '{DIST_MAX, 1'b0, '0, '0, 1'b0};

  logic                      clk;
  logic                      rst_n         = 1'b0;
  logic                      cfg_we        = 1'b0;
  logic                      cfg_index     = CFG_CONTACT_DISTANCE;
  logic [CFG_W-1:0]          cfg_wdata     = '0;
  logic                      in_valid      = 1'b0;
  logic                      in_ready;
  logic                      in_func       = FUNC_LOAD;
  logic signed [COORD_W-1:0] in_coord_x    = '0;
  logic signed [COORD_W-1:0] in_coord_y    = '0;
  logic signed [COORD_W-1:0] in_coord_z    = '0;
  logic                      in_last_point = 1'b0;
  logic                      out_valid;
  logic                      out_ready     = 1'b0;
  logic [DIST_W-1:0]         out_min_distance;
  logic                      out_stable;
  logic [CNT_A_W-1:0]        out_contact_count_a;
  logic [CNT_B_W-1:0]        out_contact_count_b;
  logic                      out_store_overflow;

  int unsigned cycle_count  = 0;
  int unsigned error_count  = 0;
  int unsigned random_items = 0;

  contact_result_t pending_results[$];
  directed_row_t   directed_rows[N_DIRECTED];

  // model state
  logic signed [COORD_W-1:0] a_x [MAX_POINTS];
  logic signed [COORD_W-1:0] a_y [MAX_POINTS];
  logic signed [COORD_W-1:0] a_z [MAX_POINTS];
  bit                        a_mark [MAX_POINTS];
  int unsigned               a_count;
  sq_t                       best_sq;
  int unsigned               b_hits;
  bit                        a_dropped;
  logic [CFG_W-1:0]          cur_contact_dist;
  logic [CNT_A_W-1:0]        cur_min_contact;

  point_set_min_distance_contact u_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_func             (in_func),
    .in_coord_x          (in_coord_x),
    .in_coord_y          (in_coord_y),
    .in_coord_z          (in_coord_z),
    .in_last_point       (in_last_point),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_min_distance    (out_min_distance),
    .out_stable          (out_stable),
    .out_contact_count_a (out_contact_count_a),
    .out_contact_count_b (out_contact_count_b),
    .out_store_overflow  (out_store_overflow)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic bit in_calm();
    return cycle_count >= CALM_START && cycle_count < CALM_END;
  endfunction

  task automatic report_mismatch(input string what, input longint unsigned got,
                                 input longint unsigned want);
    if (error_count < 40)
      $display("mismatch at cycle %0d: %s got %0d want %0d", cycle_count, what, got, want);
    error_count++;
  endtask

  // --------------------------------------------------------------------------
  // Behavioural model
  // --------------------------------------------------------------------------
  function automatic sq_t axis_sq(input logic signed [COORD_W-1:0] a,
                                  input logic signed [COORD_W-1:0] b);
    longint diff;
    diff = longint'(a) - longint'(b);
    if (diff < 0) diff = -diff;
    return sq_t'(diff * diff);
  endfunction

  function automatic logic [DIST_W-1:0] floor_sqrt(input sq_t v);
    sq_t root;
    sq_t trial;
    root = '0;
    for (int b = 27; b >= 0; b--) begin
      trial = root | (sq_t'(1) << b);
      if (trial * trial <= v) root = trial;
    end
    return (root > sq_t'(DIST_MAX)) ? DIST_MAX : root[DIST_W-1:0];
  endfunction

  // Marks need no clearing here: a load resets the mark of the slot it fills.
  task automatic clear_pass();
    a_count   = 0;
    best_sq   = NO_PAIR;
    b_hits    = 0;
    a_dropped = 1'b0;
  endtask

  task automatic predict_contact(input point_item_t it, output bit produced,
                                 output contact_result_t res);
    sq_t         thr;
    sq_t         d;
    bit          hit;
    int unsigned marked;
    produced = 1'b0;
    res      = '0;
    if (it.func == FUNC_LOAD) begin
      if (a_count >= MAX_POINTS) begin
        a_dropped = 1'b1;
      end else begin
        a_x[a_count]    = it.x;
        a_y[a_count]    = it.y;
        a_z[a_count]    = it.z;
        a_mark[a_count] = 1'b0;
        a_count++;
      end
      return;
    end
    thr = sq_t'(cur_contact_dist);
    thr = thr * thr;
    hit = 1'b0;
    for (int i = 0; i < a_count; i++) begin
      d = axis_sq(a_x[i], it.x) + axis_sq(a_y[i], it.y) + axis_sq(a_z[i], it.z);
      if (d < best_sq) best_sq = d;
      if (d < thr) begin
        a_mark[i] = 1'b1;
        hit       = 1'b1;
      end
    end
    if (hit && b_hits < CNT_B_MAX) b_hits++;
    if (!it.last) return;
    marked = 0;
    for (int i = 0; i < a_count; i++) marked += a_mark[i];
    res.min_distance = (best_sq == NO_PAIR) ? DIST_MAX : floor_sqrt(best_sq);
    res.count_a      = (marked > CNT_A_MAX) ? CNT_A_MAX : marked[CNT_A_W-1:0];
    res.count_b      = b_hits[CNT_B_W-1:0];
    res.stable       = (marked > cur_min_contact) && (b_hits > cur_min_contact);
    res.overflow     = a_dropped;
    produced         = 1'b1;
    clear_pass();
  endtask

  // --------------------------------------------------------------------------
  // Driving
  // --------------------------------------------------------------------------
  function automatic point_item_t mk_point(input logic f,
                                           input logic signed [COORD_W-1:0] x,
                                           input logic signed [COORD_W-1:0] y,
                                           input logic signed [COORD_W-1:0] z,
                                           input logic l);
    point_item_t p;
    p.func = f;
    p.x    = x;
    p.y    = y;
    p.z    = z;
    p.last = l;
    return p;
  endfunction

  // Called at a rising edge; returns at the edge that accepts the item.
  task automatic push_item(input point_item_t it, input bit checked,
                           input contact_result_t want);
    bit              produced;
    contact_result_t predicted;
    if (!in_calm() && $urandom_range(99) < 22) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_func       <= it.func;
    in_coord_x    <= it.x;
    in_coord_y    <= it.y;
    in_coord_z    <= it.z;
    in_last_point <= it.last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_contact(it, produced, predicted);
    if (produced) pending_results.push_back(checked ? want : predicted);
  endtask

  // Drop valid, hold until every expected result is out, then idle a while.
  task automatic wait_results(input int unsigned quiet);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (quiet) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [CFG_W-1:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_CONTACT_DISTANCE) cur_contact_dist = data;
    else cur_min_contact = data[CNT_A_W-1:0];
  endtask

  function automatic logic signed [COORD_W-1:0] scatter(
      input logic signed [COORD_W-1:0] c, input int unsigned spread);
    int unsigned r;
    int          off;
    r = $urandom_range(9);
    if (r == 0) return COORD_W'($urandom);
    if (r == 1) return $urandom_range(1) ? COORD_MAX : COORD_MIN;
    off = int'($urandom_range(2 * spread)) - int'(spread);
    return c + COORD_W'(off);
  endfunction

  // One pass: a cluster of A points, then B points near them, closed by a
  // last B point. The overflow pass loads past the store capacity.
  task automatic run_pass(input bit overflow_pass);
    int unsigned               n_loads;
    int unsigned               n_cmps;
    int unsigned               load_spread;
    int unsigned               span;
    int unsigned               pick;
    logic signed [COORD_W-1:0] cx;
    logic signed [COORD_W-1:0] cy;
    logic signed [COORD_W-1:0] cz;
    point_item_t               it;
    n_loads = overflow_pass ? MAX_POINTS + $urandom_range(1, 6) : $urandom_range(0, 12);
    n_cmps  = overflow_pass ? 3 : $urandom_range(1, 14);
    load_spread = (cur_contact_dist < 16) ? 48 : 3 * cur_contact_dist;
    if (load_spread > (1 << 22)) load_spread = 1 << 22;
    cx = COORD_W'($urandom);
    cy = COORD_W'($urandom);
    cz = COORD_W'($urandom);
    for (int i = 0; i < n_loads; i++) begin
      it = mk_point(FUNC_LOAD, scatter(cx, load_spread), scatter(cy, load_spread),
                    scatter(cz, load_spread), $urandom_range(1));
      push_item(it, 1'b0, EMPTY_RESULT);
      if (!overflow_pass) random_items++;
    end
    for (int i = 0; i < n_cmps; i++) begin
      if ($urandom_range(9) == 0) begin
        it = mk_point(FUNC_LOAD, scatter(cx, load_spread), scatter(cy, load_spread),
                      scatter(cz, load_spread), $urandom_range(1));
        push_item(it, 1'b0, EMPTY_RESULT);
        random_items++;
      end
      // aim inside the radius mostly, sometimes straddle it
      span = ($urandom_range(2) == 0) ? 2 * cur_contact_dist : cur_contact_dist / 2;
      if (span > (1 << 22)) span = 1 << 22;
      if (a_count != 0) begin
        pick = $urandom_range(a_count - 1);
        it = mk_point(FUNC_COMPARE, scatter(a_x[pick], span), scatter(a_y[pick], span),
                      scatter(a_z[pick], span), i == n_cmps - 1);
      end else begin
        it = mk_point(FUNC_COMPARE, scatter(cx, span), scatter(cy, span),
                      scatter(cz, span), i == n_cmps - 1);
      end
      push_item(it, 1'b0, EMPTY_RESULT);
      random_items++;
    end
    if ($urandom_range(3) == 0) wait_results(0);
  endtask

  // --------------------------------------------------------------------------
  // Result checking and receiver stalls
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : result_check
    contact_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with none expected, min_distance", out_min_distance, 0);
      end else begin
        want = pending_results.pop_front();
        if (out_min_distance !== want.min_distance)
          report_mismatch("min_distance", out_min_distance, want.min_distance);
        if (out_stable !== want.stable)
          report_mismatch("stable", out_stable, want.stable);
        if (out_contact_count_a !== want.count_a)
          report_mismatch("contact_count_a", out_contact_count_a, want.count_a);
        if (out_contact_count_b !== want.count_b)
          report_mismatch("contact_count_b", out_contact_count_b, want.count_b);
        if (out_store_overflow !== want.overflow)
          report_mismatch("store_overflow", out_store_overflow, want.overflow);
      end
    end
    out_ready <= in_calm() ? 1'b1 : ($urandom_range(99) >= 22);
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin : stimulus
    int unsigned              phase;
    int unsigned              n_passes;
    logic [CFG_W-1:0]         cd;
    logic [CNT_A_W-1:0]       mcp;
    logic [CFG_W-CNT_A_W-1:0] mcp_pad;

    cur_contact_dist = CD_RESET;
    cur_min_contact  = MCP_RESET;
    clear_pass();

    // reset radius 983, minimum count 5
    directed_rows = '{
      '{mk_point(FUNC_COMPARE, 0, 0, 0, 1'b1), 1'b1, EMPTY_RESULT},  // empty set A
      '{mk_point(FUNC_LOAD, 0, 0, 0, 1'b0), 1'b0, EMPTY_RESULT},
      '{mk_point(FUNC_LOAD, COORD_MAX, COORD_MAX, COORD_MAX, 1'b1), 1'b0, EMPTY_RESULT},
      '{mk_point(FUNC_LOAD, COORD_MIN, COORD_MIN, COORD_MIN, 1'b0), 1'b0, EMPTY_RESULT},
      '{mk_point(FUNC_COMPARE, 983, 0, 0, 1'b0), 1'b0, EMPTY_RESULT},  // on the radius
      '{mk_point(FUNC_COMPARE, 0, 0, -982, 1'b1), 1'b1,
        '{26'd982, 1'b0, 11'd1, 16'd1, 1'b0}},
      '{mk_point(FUNC_COMPARE, 5, 5, 5, 1'b0), 1'b0, EMPTY_RESULT},     // nothing stored
      '{mk_point(FUNC_LOAD, 123, -456, 789, 1'b0), 1'b0, EMPTY_RESULT},
      '{mk_point(FUNC_COMPARE, 123, -456, 789, 1'b1), 1'b1,
        '{26'd0, 1'b0, 11'd1, 16'd1, 1'b0}},
      '{mk_point(FUNC_LOAD, COORD_MAX, COORD_MAX, COORD_MAX, 1'b0), 1'b0, EMPTY_RESULT},
      '{mk_point(FUNC_COMPARE, COORD_MIN, COORD_MIN, COORD_MIN, 1'b1), 1'b0, EMPTY_RESULT},
      '{mk_point(FUNC_LOAD, COORD_MIN, 0, COORD_MAX, 1'b0), 1'b0, EMPTY_RESULT},
      '{mk_point(FUNC_LOAD, -1, -1, -1, 1'b0), 1'b0, EMPTY_RESULT},
      '{mk_point(FUNC_COMPARE, COORD_MAX, -1, COORD_MIN, 1'b0), 1'b0, EMPTY_RESULT},
      '{mk_point(FUNC_COMPARE, 0, 0, 0, 1'b0), 1'b0, EMPTY_RESULT},
      '{mk_point(FUNC_COMPARE, -1, -1, -1, 1'b1), 1'b0, EMPTY_RESULT}
    };

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    for (int r = 0; r < N_DIRECTED; r++)
      push_item(directed_rows[r].item, directed_rows[r].checked, directed_rows[r].want);

    phase = 0;
    while (random_items < RANDOM_ITEMS) begin
      wait_results(CFG_QUIET);
      case (phase)
        0: begin
          cd  = '0;
          mcp = '0;
        end
        1: begin
          cd  = '1;
          mcp = 11'd1024;
        end
        2: begin
          cd  = '1;
          mcp = '0;
        end
        3: begin
          cd  = '1;
          mcp = $urandom_range(0, 1023);
        end
        default: begin
          case ($urandom_range(9))
            0:             cd = '0;
            1:             cd = '1;
            2, 3, 4, 5, 6: cd = $urandom_range(1, 4000);
            7, 8:          cd = $urandom_range(1, 1 << 20);
            default:       cd = CFG_W'($urandom);
          endcase
          case ($urandom_range(9))
            7:       mcp = '0;
            8:       mcp = 11'd1024;
            9:       mcp = $urandom_range(0, 1024);
            default: mcp = $urandom_range(0, 8);
          endcase
        end
      endcase
      // upper bits beyond the count register must be dropped
      mcp_pad = ($urandom_range(3) == 0) ? $urandom : '0;
      write_reg(CFG_CONTACT_DISTANCE, cd);
      write_reg(CFG_MIN_CONTACT, {mcp_pad, mcp});
      n_passes = $urandom_range(3, 6);
      for (int p = 0; p < n_passes; p++) run_pass(phase == 3 && p == 0);
      phase++;
    end

    wait_results(END_QUIET);
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
